/* rtl/jsu_pkg.sv */
// Shared types and constants of the JSON string unescape block.
`default_nettype none

package jsu_pkg;

  localparam int unsigned CharW = 21;
  localparam int unsigned HexW  = 16;

  typedef enum logic [2:0] {
    PH_QUOTE = 3'd0,
    PH_ANY   = 3'd1,
    PH_ESC   = 3'd2,
    PH_HEX4  = 3'd3,
    PH_HEX3  = 3'd4,
    PH_HEX2  = 3'd5,
    PH_HEX1  = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_NOQUOTE = 3'd1,
    ERR_ESCAPE  = 3'd2,
    ERR_HEX     = 3'd3,
    ERR_ENDED   = 3'd4
  } err_e;

  localparam logic [CharW-1:0] ChQuote = 21'h22;
  localparam logic [CharW-1:0] ChBslash = 21'h5C;
  localparam logic [CharW-1:0] ChSlash = 21'h2F;
  localparam logic [CharW-1:0] ChB = 21'h62;
  localparam logic [CharW-1:0] ChF = 21'h66;
  localparam logic [CharW-1:0] ChN = 21'h6E;
  localparam logic [CharW-1:0] ChT = 21'h74;
  localparam logic [CharW-1:0] ChU = 21'h75;
  localparam logic [CharW-1:0] ChBackspace = 21'h08;
  localparam logic [CharW-1:0] ChFormFeed = 21'h0C;
  localparam logic [CharW-1:0] ChNewline = 21'h0A;
  localparam logic [CharW-1:0] ChTab = 21'h09;

  typedef struct packed {
    logic             ended;
    logic [CharW-1:0] ch;
  } item_t;

  typedef struct packed {
    err_e             err;
    logic [CharW-1:0] ch;
    kind_e            kind;
  } result_t;

endpackage

`default_nettype wire

/* rtl/jsu_in_reg.sv */
// Input register that holds one accepted transaction until the decoder takes it.
`default_nettype none

module jsu_in_reg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire jsu_pkg::item_t in_item_i,
  input  wire logic          advance_i,
  output logic               item_valid_o,
  output jsu_pkg::item_t     item_o
);
  import jsu_pkg::*;

  logic  valid_d, valid_q;
  logic  load;
  item_t item_q;

  assign in_ready_o = !valid_q || advance_i;
  assign load       = in_valid_i && in_ready_o;
  assign valid_d    = load || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

`default_nettype wire

/* rtl/jsu_decode.sv */
// Parse state and the per-character decode logic of the unescaper.
`default_nettype none

module jsu_decode (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire jsu_pkg::item_t item_i,
  input  wire logic           advance_i,
  output logic                has_result_o,
  output jsu_pkg::result_t    result_o
);
  import jsu_pkg::*;

  phase_e          phase_d, phase_q;
  logic [HexW-1:0] hex_d, hex_q;
  logic            digit_ok;
  logic [3:0]      digit;
  logic [CharW-1:0] c;

  assign c = item_i.ch;

  always_comb begin
    digit_ok = 1'b1;
    digit    = 4'd0;
    if (c >= 21'h30 && c <= 21'h39) begin
      digit = 4'(c - 21'h30);
    end else if (c >= 21'h61 && c <= 21'h66) begin
      digit = 4'(c - 21'h57);
    end else if (c >= 21'h41 && c <= 21'h46) begin
      digit = 4'(c - 21'h37);
    end else begin
      digit_ok = 1'b0;
    end
  end

  always_comb begin
    phase_d = phase_q;
    hex_d   = hex_q;
    if (item_i.ended) begin
      phase_d = PH_QUOTE;
      hex_d   = '0;
    end else begin
      case (phase_q)
        PH_ANY: begin
          if (c == ChBslash) begin
            phase_d = PH_ESC;
          end else if (c == ChQuote) begin
            phase_d = PH_QUOTE;
            hex_d   = '0;
          end
        end
        PH_ESC: begin
          if (c == ChU) begin
            phase_d = PH_HEX4;
            hex_d   = '0;
          end else if (c == ChQuote || c == ChBslash || c == ChSlash || c == ChB ||
                       c == ChF || c == ChN || c == ChT) begin
            phase_d = PH_ANY;
          end else begin
            phase_d = PH_QUOTE;
            hex_d   = '0;
          end
        end
        PH_HEX4, PH_HEX3, PH_HEX2, PH_HEX1: begin
          if (!digit_ok) begin
            phase_d = PH_QUOTE;
            hex_d   = '0;
          end else begin
            hex_d = {hex_q[HexW-5:0], digit};
            if (phase_q == PH_HEX1) begin
              phase_d = PH_ANY;
            end else begin
              phase_d = phase_e'(phase_q + 3'd1);
            end
          end
        end
        default: begin
          if (c == ChQuote) begin
            phase_d = PH_ANY;
          end else begin
            phase_d = PH_QUOTE;
          end
          hex_d = '0;
        end
      endcase
    end
  end

  always_comb begin
    has_result_o  = 1'b0;
    result_o.kind = KIND_CHAR;
    result_o.ch   = '0;
    result_o.err  = ERR_NONE;
    if (item_i.ended) begin
      has_result_o  = 1'b1;
      result_o.kind = KIND_ERR;
      result_o.err  = ERR_ENDED;
    end else begin
      case (phase_q)
        PH_ANY: begin
          if (c == ChQuote) begin
            has_result_o  = 1'b1;
            result_o.kind = KIND_DONE;
          end else if (c != ChBslash) begin
            has_result_o = 1'b1;
            result_o.ch  = c;
          end
        end
        PH_ESC: begin
          has_result_o = (c != ChU);
          if (c == ChQuote || c == ChBslash || c == ChSlash) begin
            result_o.ch = c;
          end else if (c == ChB) begin
            result_o.ch = ChBackspace;
          end else if (c == ChF) begin
            result_o.ch = ChFormFeed;
          end else if (c == ChN) begin
            result_o.ch = ChNewline;
          end else if (c == ChT) begin
            result_o.ch = ChTab;
          end else if (c != ChU) begin
            result_o.kind = KIND_ERR;
            result_o.err  = ERR_ESCAPE;
          end
        end
        PH_HEX4, PH_HEX3, PH_HEX2, PH_HEX1: begin
          if (!digit_ok) begin
            has_result_o  = 1'b1;
            result_o.kind = KIND_ERR;
            result_o.err  = ERR_HEX;
          end else if (phase_q == PH_HEX1) begin
            has_result_o = 1'b1;
            result_o.ch  = CharW'({hex_q[HexW-5:0], digit});
          end
        end
        default: begin
          if (c != ChQuote) begin
            has_result_o  = 1'b1;
            result_o.kind = KIND_ERR;
            result_o.err  = ERR_NOQUOTE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_QUOTE;
      hex_q   <= '0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      hex_q   <= hex_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/jsu_out_reg.sv */
// Result register that holds one result transaction until the receiver takes it.
`default_nettype none

module jsu_out_reg (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire jsu_pkg::result_t result_i,
  output logic                  can_load_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output jsu_pkg::result_t      result_o
);
  import jsu_pkg::*;

  logic    valid_d, valid_q;
  result_t result_q;

  assign can_load_o = !valid_q || out_ready_i;
  assign valid_d    = load_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

`default_nettype wire

/* rtl/json_string_unescape_top.sv */
// Top level of the JSON string unescaper.
//
// The slave stream carries one code point per transaction: tdata[20:0] is the
// code point and tuser[0] marks the end of the input. The master stream gives
// at most one result per input transaction: tuser holds the result kind
// (character, string complete or error), tdata[20:0] the decoded character and
// tdata[23:21] the error code. An escape's opening backslash, the letter u and the
// first three hex digits of an escape, and an opening quote produce no result.
// An accepted transaction lands in the input register, is decoded combinationally
// from there and is loaded into the result register when the decoder advances.
// One transaction per cycle is sustained while the receiver takes results; the
// parse state is updated once per character as the decoder advances.
// When the receiver stalls, the result register holds its transaction and the
// input register absorbs one more; tready falls only when both are full.
// Reset empties both registers and returns the parser to expecting a quote.
`default_nettype none

module json_string_unescape_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [23:0] s_axis_tdata_i,  // char_value[20:0], zero fill
  input  wire logic [0:0]  s_axis_tuser_i,  // input_ended[0]
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [23:0]      m_axis_tdata_o,  // decoded_char[20:0], error_code[23:21]
  output logic [1:0]       m_axis_tuser_o   // result_kind[1:0]
);
  import jsu_pkg::*;

  item_t   in_item, item;
  result_t dec_result, out_result;
  logic    item_valid, has_result, can_load, advance;

  assign in_item.ch    = s_axis_tdata_i[CharW-1:0];
  assign in_item.ended = s_axis_tuser_i[0];

  assign advance = item_valid && (!has_result || can_load);

  jsu_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_item_i    (in_item),
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  jsu_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .advance_i    (advance),
    .has_result_o (has_result),
    .result_o     (dec_result)
  );

  jsu_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && has_result),
    .result_i    (dec_result),
    .can_load_o  (can_load),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .result_o    (out_result)
  );

  assign m_axis_tdata_o = {out_result.err, out_result.ch};
  assign m_axis_tuser_o = out_result.kind;

endmodule

`default_nettype wire
